### hdl/wwkc_pkg.sv
package wwkc_pkg;

    // Kinds of input item.
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_NEW_SET = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } ctrl_state_t;

    // Character constants used for case folding and letter detection, and the count limit.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] COUNT_MAX    = 8'd255;

    // One input item.
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] keyword_slot;
        logic [4:0] char_pos;
        logic [7:0] char_code;
        logic       is_last;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] match_count;
        logic [7:0] best_count;
        logic       reaches_best;
    } out_item_t;

endpackage

### hdl/whole_word_keyword_counter_unit.sv
// Whole-word keyword counter.
// Input channel s_valid/s_ready/s_item carries one item per handshake: a keyword
// byte to load into the table, a text byte, or a request to start a new set.
// Result channel m_valid/m_ready/m_item gives one item per finished line: the
// line's whole-word match count, the best count since the set started, and a
// flag set when this line reaches that best.
// Load and new-set items are handled without a sweep. A text byte that is a letter,
// or a separator that closes an open word, costs one sweep of the table after it is
// accepted; a separator with no word open needs no sweep. The last byte of a line
// needs up to two sweeps before its result appears. The sweep reads one table slot
// per cycle from the character and length memories and sets the rate.
// Reset clears the table's valid flags, the word in progress and all counts; the
// character memory is not cleared. A stalled receiver holds the result in the
// output register; the next text byte is still taken, and only a further line
// end waits until the held result is taken.
module whole_word_keyword_counter_unit import wwkc_pkg::*; #(
    parameter int NUM_KEYWORDS    = 32,
    parameter int MAX_KEYWORD_LEN = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int SLOT_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int POS_W  = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_KEYWORD_LEN + 2);

    logic                    chars_we;
    logic [SLOT_W+POS_W-1:0] chars_waddr;
    logic [7:0]              chars_wdata;
    logic [SLOT_W+POS_W-1:0] chars_raddr;
    logic [7:0]              chars_rdata;
    logic                    len_we;
    logic [SLOT_W-1:0]       len_waddr;
    logic [LEN_W-1:0]        len_wdata;
    logic [SLOT_W-1:0]       len_raddr;
    logic [LEN_W-1:0]        len_rdata;
    logic                    rd_en;
    logic                    res_valid;
    logic                    res_ready;
    out_item_t               res_item;

    // Sequencer and per-slot match state.
    wwkc_ctrl #(
        .NUM_KEYWORDS    (NUM_KEYWORDS),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .SLOT_W          (SLOT_W),
        .POS_W           (POS_W),
        .LEN_W           (LEN_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .chars_we    (chars_we),
        .chars_waddr (chars_waddr),
        .chars_wdata (chars_wdata),
        .chars_raddr (chars_raddr),
        .chars_rdata (chars_rdata),
        .len_we      (len_we),
        .len_waddr   (len_waddr),
        .len_wdata   (len_wdata),
        .len_raddr   (len_raddr),
        .len_rdata   (len_rdata),
        .rd_en       (rd_en),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item)
    );

    // Keyword characters, one row of positions per slot.
    wwkc_ram #(
        .DATA_W (8),
        .ADDR_W (SLOT_W + POS_W)
    ) u_chars_ram (
        .aclk  (aclk),
        .we    (chars_we),
        .waddr (chars_waddr),
        .wdata (chars_wdata),
        .re    (rd_en),
        .raddr (chars_raddr),
        .rdata (chars_rdata)
    );

    // Keyword lengths, one entry per slot.
    wwkc_ram #(
        .DATA_W (LEN_W),
        .ADDR_W (SLOT_W)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (rd_en),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    // Output register between the sequencer and the receiver.
    wwkc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_item  (res_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

`ifndef SYNTHESIS
    // The best count never falls below the line's own count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.best_count >= m_item.match_count))
        else $error("best count below line count");

    // The reach flag agrees with the two counts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.reaches_best == (m_item.match_count == m_item.best_count)))
        else $error("reach flag disagrees with counts");

    // A line end is never finished in the cycle it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_item.kind == KIND_TEXT) && s_item.is_last) |=> !s_ready)
        else $error("input taken again right after a line end");
`endif

endmodule

### hdl/wwkc_ram.sv
module wwkc_ram import wwkc_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/wwkc_out_reg.sv
module wwkc_out_reg import wwkc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  out_item_t in_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // The register can take a new item when empty or when its item leaves now.
    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

### hdl/wwkc_ctrl.sv
module wwkc_ctrl import wwkc_pkg::*; #(
    parameter int NUM_KEYWORDS    = 32,
    parameter int MAX_KEYWORD_LEN = 32,
    parameter int SLOT_W          = 5,
    parameter int POS_W           = 5,
    parameter int LEN_W           = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_item,
    // Keyword character memory
    output logic                      chars_we,
    output logic [SLOT_W+POS_W-1:0]   chars_waddr,
    output logic [7:0]                chars_wdata,
    output logic [SLOT_W+POS_W-1:0]   chars_raddr,
    input  logic [7:0]                chars_rdata,
    // Keyword length memory
    output logic                      len_we,
    output logic [SLOT_W-1:0]         len_waddr,
    output logic [LEN_W-1:0]          len_wdata,
    output logic [SLOT_W-1:0]         len_raddr,
    input  logic [LEN_W-1:0]          len_rdata,
    output logic                      rd_en,
    // Result towards the output register
    output logic                      res_valid,
    input  logic                      res_ready,
    output out_item_t                 res_item
);

    localparam int CNT_W = $clog2(NUM_KEYWORDS + 1);

    ctrl_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]      rd_slot_reg, rd_slot_next;
    logic                   letter_reg, letter_next;
    logic                   last_reg, last_next;
    logic [7:0]             char_reg, char_next;
    logic [LEN_W-1:0]       wp_reg, wp_next;
    logic [7:0]             lm_reg, lm_next;
    logic [7:0]             best_reg, best_next;
    logic [NUM_KEYWORDS-1:0] sm_reg, sm_next;
    logic [NUM_KEYWORDS-1:0] kv_reg, kv_next;

    logic                   accept;
    logic                   load_ok;
    logic                   sweep_done;
    logic                   wp_in_range;
    logic [7:0]             folded;
    logic                   is_letter;
    logic [SLOT_W-1:0]      load_slot;
    logic [7:0]             best_upd;

    assign accept      = s_valid && s_ready;
    assign load_ok     = (32'(s_item.keyword_slot) < NUM_KEYWORDS) &&
                         (32'(s_item.char_pos) < MAX_KEYWORD_LEN);
    assign load_slot   = SLOT_W'(s_item.keyword_slot);
    assign sweep_done  = (cnt_reg == CNT_W'(NUM_KEYWORDS));
    assign wp_in_range = (wp_reg < LEN_W'(MAX_KEYWORD_LEN));

    // Fold upper case to lower case and detect a letter.
    always_comb begin
        folded = s_item.char_code;
        if (s_item.char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            folded = s_item.char_code + CASE_OFFSET;
        end
        is_letter = folded inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
    end

    // Table writes happen only on an accepted load item.
    assign chars_we    = accept && (s_item.kind == KIND_LOAD) && load_ok;
    assign chars_waddr = {load_slot, POS_W'(s_item.char_pos)};
    assign chars_wdata = s_item.char_code;
    assign len_we      = chars_we && s_item.is_last;
    assign len_waddr   = load_slot;
    assign len_wdata   = LEN_W'({1'b0, s_item.char_pos} + 6'd1);

    // Both memories are read at the slot under the sweep counter.
    assign chars_raddr = {cnt_reg[SLOT_W-1:0], wp_reg[POS_W-1:0]};
    assign len_raddr   = cnt_reg[SLOT_W-1:0];

    // Result payload with the best count updated by this line.
    assign best_upd = (lm_reg > best_reg) ? lm_reg : best_reg;
    always_comb begin
        res_item.match_count  = lm_reg;
        res_item.best_count   = best_upd;
        res_item.reaches_best = (lm_reg == best_upd);
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_item.kind == KIND_TEXT)) begin
                    if (is_letter || (wp_reg != '0)) begin
                        state_next = ST_SWEEP;
                    end else if (s_item.is_last) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (letter_reg) begin
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory control outputs.
    always_comb begin
        s_ready   = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SWEEP: begin
                rd_en = !sweep_done;
            end
            ST_RESULT: begin
                res_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath: item decode, per-slot sweep and line totals.
    always_comb begin
        cnt_next      = cnt_reg;
        rd_valid_next = rd_en;
        rd_slot_next  = cnt_reg[SLOT_W-1:0];
        letter_next   = letter_reg;
        last_next     = last_reg;
        char_next     = char_reg;
        wp_next       = wp_reg;
        lm_next       = lm_reg;
        best_next     = best_reg;
        sm_next       = sm_reg;
        kv_next       = kv_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (kind_t'(s_item.kind))
                        KIND_LOAD: begin
                            // A freshly loaded slot cannot match the current word.
                            if (load_ok) begin
                                sm_next[load_slot] = 1'b0;
                                if (s_item.is_last) begin
                                    kv_next[load_slot] = 1'b1;
                                end
                            end
                        end
                        KIND_NEW_SET: begin
                            kv_next   = '0;
                            sm_next   = '1;
                            wp_next   = '0;
                            lm_next   = '0;
                            best_next = '0;
                        end
                        KIND_TEXT: begin
                            char_next   = folded;
                            last_next   = s_item.is_last;
                            letter_next = is_letter;
                            cnt_next    = '0;
                            // A separator with no word open only restarts the word.
                            if (!is_letter && (wp_reg == '0)) begin
                                sm_next = '1;
                            end
                        end
                        default: begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (!sweep_done) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // Handle the slot whose memory data has just arrived.
                if (rd_valid_reg) begin
                    if (letter_reg) begin
                        sm_next[rd_slot_reg] = sm_reg[rd_slot_reg] && wp_in_range &&
                                               (chars_rdata == char_reg);
                    end else if (kv_reg[rd_slot_reg] && sm_reg[rd_slot_reg] &&
                                 (len_rdata == wp_reg) && (wp_reg != '0) &&
                                 (lm_reg != COUNT_MAX)) begin
                        lm_next = lm_reg + 8'd1;
                    end
                end
                // Close the sweep: advance the word or end it.
                if (sweep_done) begin
                    if (letter_reg) begin
                        if (wp_reg <= LEN_W'(MAX_KEYWORD_LEN)) begin
                            wp_next = wp_reg + LEN_W'(1);
                        end
                        if (last_reg) begin
                            letter_next = 1'b0;
                            cnt_next    = '0;
                        end
                    end else begin
                        sm_next = '1;
                        wp_next = '0;
                    end
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    lm_next   = '0;
                    best_next = best_upd;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            letter_reg   <= 1'b0;
            last_reg     <= 1'b0;
            wp_reg       <= '0;
            lm_reg       <= '0;
            best_reg     <= '0;
            sm_reg       <= '1;
            kv_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            letter_reg   <= letter_next;
            last_reg     <= last_next;
            wp_reg       <= wp_next;
            lm_reg       <= lm_next;
            best_reg     <= best_next;
            sm_reg       <= sm_next;
            kv_reg       <= kv_next;
        end
    end

    // Payload registers without reset.
    always_ff @(posedge aclk) begin
        rd_slot_reg <= rd_slot_next;
        char_reg    <= char_next;
    end

endmodule
